// File: rtl/centered_text_line_glyph_writer_defines.svh
// Assertion macros for the centred text-line glyph writer
`ifndef CENTERED_TEXT_LINE_GLYPH_WRITER_DEFINES_SVH
`define CENTERED_TEXT_LINE_GLYPH_WRITER_DEFINES_SVH

// checked outside reset
`define CTLGW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CTLGW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ctlgw_pkg.sv
// Package: constants, job type and glyph ROM of the centred text-line glyph writer
package ctlgw_pkg;

  localparam int DISPLAY_COLUMNS = 128;
  localparam int PAGE_ROWS       = 4;
  localparam int CELL_WIDTH      = 6;

  localparam int GLYPH_COLS      = 5;
  localparam int WRITES_PER_CHAR = 6;
  localparam int FIT_LEN         = DISPLAY_COLUMNS / CELL_WIDTH;
  localparam int MAX_LEN         = (FIT_LEN < 31) ? FIT_LEN : 31;

  localparam int CUR_W  = $clog2(DISPLAY_COLUMNS + 1);
  localparam int LEN_W  = 5;
  localparam int PAGE_W = 3;
  localparam int CODE_W = 8;
  localparam int ADDR_W = 9;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 3;
  localparam int IDX_W  = 5;

  localparam logic [CODE_W-1:0] CHAR_A = 8'h41;
  localparam logic [CODE_W-1:0] CHAR_Z = 8'h5A;

  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [CNT_W-1:0]  count;
    logic              letter;
    logic [IDX_W-1:0]  glyph_idx;
  } job_t;

  localparam logic [DATA_W-1:0] GLYPH_ROM [26][5] = '{
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  function automatic logic [DATA_W-1:0] glyph_byte(
    input logic             letter,
    input logic [IDX_W-1:0] idx,
    input logic [CNT_W-1:0] col
  );
    logic [DATA_W-1:0] d;
    d = '0;
    if (letter && ({1'b0, col} < 4'(GLYPH_COLS)) && ({1'b0, idx} < 6'd26)) begin
      d = GLYPH_ROM[idx][col];
    end
    return d;
  endfunction

endpackage

// File: rtl/ctlgw_line_ctrl.sv
// Line state: length cap, centring, cursor advance and job formation per character
module ctlgw_line_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctlgw_pkg::PAGE_W-1:0]  in_page,
  input  logic [ctlgw_pkg::CODE_W-1:0]  in_char_code,
  input  logic [ctlgw_pkg::CODE_W-1:0]  in_line_length,
  input  logic                          in_first_char,
  output logic                          job_valid,
  input  logic                          job_ready,
  output ctlgw_pkg::job_t               job
);
  import ctlgw_pkg::*;

  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [LEN_W-1:0]  index_r, index_nxt;
  logic [LEN_W-1:0]  cap_r, cap_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;

  logic [LEN_W-1:0]  len_c;
  logic [CUR_W:0]    start_w;
  logic [CUR_W-1:0]  cur_e;
  logic [LEN_W-1:0]  idx_e, cap_e;
  logic [PAGE_W-1:0] page_e;
  logic              active, page_ok, accept;
  logic [CUR_W:0]    rem;
  logic [CNT_W-1:0]  count;

  assign accept   = in_valid && in_ready;
  assign in_ready = job_ready;

  always_comb begin
    if (in_line_length > CODE_W'(MAX_LEN)) begin
      len_c = LEN_W'(MAX_LEN);
    end else begin
      len_c = in_line_length[LEN_W-1:0];
    end
    start_w = ((CUR_W+1)'(DISPLAY_COLUMNS) - (CUR_W+1)'(len_c) * (CUR_W+1)'(CELL_WIDTH)) >> 1;
    if (in_first_char) begin
      cur_e  = start_w[CUR_W-1:0];
      idx_e  = '0;
      cap_e  = len_c;
      page_e = in_page;
    end else begin
      cur_e  = cursor_r;
      idx_e  = index_r;
      cap_e  = cap_r;
      page_e = page_r;
    end
    active  = idx_e < cap_e;
    page_ok = {1'b0, page_e} < (PAGE_W+1)'(PAGE_ROWS);
    rem     = (CUR_W+1)'(DISPLAY_COLUMNS) - (CUR_W+1)'(cur_e);
    if (!active || !page_ok || ({1'b0, cur_e} >= (CUR_W+1)'(DISPLAY_COLUMNS))) begin
      count = '0;
    end else if (rem >= (CUR_W+1)'(WRITES_PER_CHAR)) begin
      count = CNT_W'(WRITES_PER_CHAR);
    end else begin
      count = rem[CNT_W-1:0];
    end

    job.base_addr = ADDR_W'(32'(page_e) * DISPLAY_COLUMNS + 32'(cur_e));
    job.count     = count;
    job.letter    = (in_char_code >= CHAR_A) && (in_char_code <= CHAR_Z);
    job.glyph_idx = IDX_W'(in_char_code - CHAR_A);
    job_valid     = in_valid && (count != '0);

    cursor_nxt = cur_e;
    index_nxt  = idx_e;
    cap_nxt    = cap_e;
    page_nxt   = page_e;
    if (active) begin
      cursor_nxt = CUR_W'(cur_e + CUR_W'(CELL_WIDTH));
      index_nxt  = idx_e + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      index_r  <= '0;
      cap_r    <= '0;
      page_r   <= '0;
    end else if (accept) begin
      cursor_r <= cursor_nxt;
      index_r  <= index_nxt;
      cap_r    <= cap_nxt;
      page_r   <= page_nxt;
    end
  end

endmodule

// File: rtl/ctlgw_col_emit.sv
// Column emitter: holds one character job and issues its writes one per cycle unless out_ready stalls
module ctlgw_col_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  ctlgw_pkg::job_t               job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctlgw_pkg::ADDR_W-1:0]  out_write_address,
  output logic [ctlgw_pkg::DATA_W-1:0]  out_write_data,
  output logic                          out_last_write
);
  import ctlgw_pkg::*;

  job_t              job_r;
  logic              busy_r;
  logic [CNT_W-1:0]  col_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  logic              last_r;
  logic              step, last;

  assign step      = busy_r && (!out_valid_r || out_ready);
  assign last      = col_r == (job_r.count - CNT_W'(1));
  assign job_ready = !busy_r || (step && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
    end else if (job_valid && job_ready) begin
      busy_r <= 1'b1;
      col_r  <= '0;
    end else if (step && last) begin
      busy_r <= 1'b0;
    end else if (step) begin
      col_r <= col_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      addr_r <= job_r.base_addr + ADDR_W'(col_r);
      data_r <= glyph_byte(job_r.letter, job_r.glyph_idx, col_r);
      last_r <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = addr_r;
  assign out_write_data    = data_r;
  assign out_last_write    = last_r;

endmodule

// File: rtl/centered_text_line_glyph_writer.sv
// Top level of the centred text-line glyph writer
// A character's first write is registered in the column emitter after its job is captured.
// Throughput: one write per cycle, set by the single output write port, unless out_ready stalls;
// a character makes up to 6 writes; characters with no writes are taken with no emitter job.
// Reset (rst_n low, synchronous) clears cursor, index, length, page and all valid flags.
module centered_text_line_glyph_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctlgw_pkg::PAGE_W-1:0]  in_page,
  input  logic [ctlgw_pkg::CODE_W-1:0]  in_char_code,
  input  logic [ctlgw_pkg::CODE_W-1:0]  in_line_length,
  input  logic                          in_first_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctlgw_pkg::ADDR_W-1:0]  out_write_address,
  output logic [ctlgw_pkg::DATA_W-1:0]  out_write_data,
  output logic                          out_last_write
);
  import ctlgw_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  ctlgw_line_ctrl u_line_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_page        (in_page),
    .in_char_code   (in_char_code),
    .in_line_length (in_line_length),
    .in_first_char  (in_first_char),
    .job_valid      (job_valid),
    .job_ready      (job_ready),
    .job            (job)
  );

  ctlgw_col_emit u_col_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (job_valid),
    .job_ready         (job_ready),
    .job               (job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_last_write    (out_last_write)
  );

endmodule

// File: rtl/ctlgw_checker.sv
// Port-level checker for the centred text-line glyph writer, with its bind
`include "centered_text_line_glyph_writer_defines.svh"

module ctlgw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ctlgw_pkg::ADDR_W-1:0]  out_write_address,
  input logic [ctlgw_pkg::DATA_W-1:0]  out_write_data,
  input logic                          out_last_write
);
  import ctlgw_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  `CTLGW_ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid, "out_valid after reset")
  `CTLGW_ASSERT(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=>
      out_valid && $stable(out_write_address) && $stable(out_write_data),
    "output changed while stalled")
  `CTLGW_ASSERT(a_addr_seq, clk, rst_n,
    out_xfer && $past(out_xfer) && $past(!out_last_write) |->
      out_write_address == $past(out_write_address) + ADDR_W'(1),
    "write address not consecutive within a character")
  `CTLGW_ASSERT(a_spacer_zero, clk, rst_n,
    out_valid && out_last_write && (out_write_address[6:0] != 7'd127) |->
      out_write_data == '0,
    "final write of a character is not a blank spacer")

endmodule

bind centered_text_line_glyph_writer ctlgw_checker u_ctlgw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_write_address (out_write_address),
  .out_write_data    (out_write_data),
  .out_last_write    (out_last_write)
);

// File: test/ctlgw_result_checker.sv
// Checker for the glyph writer: predicts framebuffer writes per character and compares them
module ctlgw_result_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [ctlgw_pkg::PAGE_W-1:0] in_page,
  input  logic [ctlgw_pkg::CODE_W-1:0] in_char_code,
  input  logic [ctlgw_pkg::CODE_W-1:0] in_line_length,
  input  logic                         in_first_char,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [ctlgw_pkg::ADDR_W-1:0] out_write_address,
  input  logic [ctlgw_pkg::DATA_W-1:0] out_write_data,
  input  logic                         out_last_write,
  output int                           mismatch_count,
  output int                           writes_pending,
  output int                           writes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_COLS   = ctlgw_pkg::DISPLAY_COLUMNS;
  localparam int SCREEN_PAGES  = ctlgw_pkg::PAGE_ROWS;
  localparam int CHAR_PITCH    = ctlgw_pkg::CELL_WIDTH;
  localparam int GLYPH_WIDTH   = 5;
  localparam int CELL_WRITES   = 6;
  localparam int LONGEST_LINE  = (SCREEN_COLS / CHAR_PITCH < 31) ? SCREEN_COLS / CHAR_PITCH : 31;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [7:0] FIRST_LETTER = "A";
  localparam logic [7:0] LAST_LETTER  = "Z";

  localparam logic [7:0] FONT [26][5] = '{
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  typedef struct packed {
    logic [ctlgw_pkg::ADDR_W-1:0] addr;
    logic [ctlgw_pkg::DATA_W-1:0] data;
    logic                         last;
  } fb_write_t;

  fb_write_t expected_writes [$];
  fb_write_t oldest;

  int         line_cursor;
  int         chars_done;
  int         line_len;
  logic [2:0] line_pg;
  int         fail_total = 0;
  int         seen_total = 0;

  task automatic queue_char_writes(input logic [2:0] pg, input logic [7:0] code,
                                   input logic [7:0] len, input logic first);
    int        n_writes;
    int        col;
    logic      is_letter;
    fb_write_t w;
    if (first) begin
      line_len    = (int'(len) > LONGEST_LINE) ? LONGEST_LINE : int'(len);
      line_pg     = pg;
      chars_done  = 0;
      line_cursor = (SCREEN_COLS - line_len * CHAR_PITCH) / 2;
    end
    if (chars_done >= line_len) return;
    if (int'(line_pg) < SCREEN_PAGES) begin
      is_letter = (code >= FIRST_LETTER) && (code <= LAST_LETTER);
      // writes stop at the right edge of the screen
      n_writes  = SCREEN_COLS - line_cursor;
      if (n_writes > CELL_WRITES) n_writes = CELL_WRITES;
      for (col = 0; col < n_writes; col++) begin
        w.addr = 9'(int'(line_pg) * SCREEN_COLS + line_cursor + col);
        w.data = (is_letter && col < GLYPH_WIDTH) ? FONT[code - FIRST_LETTER][col] : 8'h00;
        w.last = (col == n_writes - 1);
        expected_writes.push_back(w);
      end
    end
    line_cursor += CHAR_PITCH;
    chars_done++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_writes.delete();
      line_cursor = 0;
      chars_done  = 0;
      line_len    = 0;
      line_pg     = '0;
    end else begin
      // output side first: a write never stems from a character taken at the same edge
      if (out_valid && out_ready) begin
        seen_total++;
        if (expected_writes.size() == 0) begin
          if (fail_total < REPORT_LIMIT)
            $display("[%0t] unexpected write: addr %0d data %02h last %0b", $realtime,
                     out_write_address, out_write_data, out_last_write);
          fail_total++;
        end else begin
          oldest = expected_writes.pop_front();
          if (oldest.addr !== out_write_address || oldest.data !== out_write_data ||
              oldest.last !== out_last_write) begin
            if (fail_total < REPORT_LIMIT)
              $display({"[%0t] write mismatch: expected addr %0d data %02h last %0b,",
                        " got addr %0d data %02h last %0b"},
                       $realtime, oldest.addr, oldest.data, oldest.last,
                       out_write_address, out_write_data, out_last_write);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready)
        queue_char_writes(in_page, in_char_code, in_line_length, in_first_char);
    end
    mismatch_count <= fail_total;
    writes_pending <= expected_writes.size();
    writes_checked <= seen_total;
  end

endmodule

// File: test/tb_top.sv
// Testbench top: drives text lines into the glyph writer and reports the verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_ITEM = 150;
  localparam int QUIET_FROM   = 250;
  localparam int QUIET_TO     = 330;
  localparam int IDLE_PCT     = 35;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic [ctlgw_pkg::PAGE_W-1:0] in_page        = '0;
  logic [ctlgw_pkg::CODE_W-1:0] in_char_code   = '0;
  logic [ctlgw_pkg::CODE_W-1:0] in_line_length = '0;
  logic                         in_first_char  = 1'b0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic [ctlgw_pkg::ADDR_W-1:0] out_write_address;
  logic [ctlgw_pkg::DATA_W-1:0] out_write_data;
  logic                         out_last_write;

  int   mismatch_count;
  int   writes_pending;
  int   writes_checked;

  int   items_sent = 0;
  int   lines_sent = 0;
  int   directed_items;
  logic quiet      = 1'b0;
  logic held       = 1'b0;

  centered_text_line_glyph_writer u_dut (.*);

  ctlgw_result_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // leaves the task at the edge where the character transfer takes place
  task automatic send_char(input logic [2:0] pg, input logic [7:0] code,
                           input logic [7:0] len, input logic first);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_page        <= pg;
    in_char_code   <= code;
    in_line_length <= len;
    in_first_char  <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (first) lines_sent++;
    quiet = (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(4) != 0)
      return 8'($urandom_range(ctlgw_pkg::CHAR_Z, ctlgw_pkg::CHAR_A));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_line();
    int         kind;
    int         cap;
    int         n_chars;
    int         i;
    logic [2:0] pg;
    logic [7:0] len;
    kind = $urandom_range(99);
    pg   = ($urandom_range(9) < 8) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 4));
    if (kind < 75)      len = 8'($urandom_range(21, 1));
    else if (kind < 88) len = 8'($urandom_range(255, 22));
    else if (kind < 93) len = 8'd0;
    else                len = 8'($urandom_range(4, 1));
    cap     = (int'(len) > ctlgw_pkg::MAX_LEN) ? ctlgw_pkg::MAX_LEN : int'(len);
    n_chars = cap;
    case ($urandom_range(9))
      0: n_chars = $urandom_range(cap);
      1: n_chars = cap + $urandom_range(3, 1);
      default: ;
    endcase
    if (n_chars < 1) n_chars = 1;
    for (i = 0; i < n_chars; i++) begin
      if (i == 0) send_char(pg, pick_code(), len, 1'b1);
      else        send_char(3'($urandom_range(7)), pick_code(), 8'($urandom_range(255)), 1'b0);
    end
  endtask

  // receiver: random stalls, one long hold-off so the block backs up into its input
  initial begin
    @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AT_ITEM) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_char(3'd0, "A", 8'd5, 1'b0);         // no line started yet
    send_char(3'd0, "B", 8'd0, 1'b1);         // empty line
    send_char(3'd0, "C", 8'd0, 1'b0);
    send_char(3'd2, "A", 8'd1, 1'b1);         // single centred character
    send_char(3'd2, "B", 8'd1, 1'b0);         // past the end of the line
    send_char(3'd7, "Z", 8'd255, 1'b1);       // page off the display
    send_char(3'd4, "M", 8'd3, 1'b1);
    send_char(3'd4, "N", 8'd3, 1'b0);
    send_char(3'd3, "Z", 8'd22, 1'b1);        // over-long line, capped
    send_char(3'd0, 8'h40, 8'd0, 1'b0);       // codes either side of the letters
    send_char(3'd7, 8'h5B, 8'd255, 1'b0);
    send_char(3'd0, 8'h00, 8'd0, 1'b0);
    send_char(3'd0, 8'hFF, 8'd0, 1'b0);
    send_char(3'd0, 8'h61, 8'd0, 1'b0);
    send_char(3'd1, "H", 8'd2, 1'b1);
    send_char(3'd6, "I", 8'd0, 1'b0);         // page ignored after the first character
    send_char(3'd5, "J", 8'd0, 1'b0);
    send_char(3'd0, "Q", 8'd21, 1'b1);
    send_char(3'd3, "W", 8'd128, 1'b1);       // new line before the old one is done
    directed_items = items_sent;

    while (items_sent < directed_items + RANDOM_ITEMS) send_line();
    in_valid <= 1'b0;

    do @(negedge clk); while (writes_pending != 0);
    repeat (20) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d characters over %0d lines, %0d of them directed.",
             items_sent, lines_sent, directed_items);
    $display("Checked %0d framebuffer writes, with one long output hold-off.", writes_checked);
    if (writes_pending != 0)
      $display("%0d expected writes never arrived", writes_pending);
    if (mismatch_count == 0 && writes_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ctlgw_pkg.sv
rtl/ctlgw_line_ctrl.sv
rtl/ctlgw_col_emit.sv
rtl/centered_text_line_glyph_writer.sv
rtl/ctlgw_checker.sv
test/ctlgw_result_checker.sv
test/tb_top.sv
